FILE: rtl/core/lbrt_pkg.sv
`timescale 1ns / 1ps

package lbrt_pkg;

   localparam int WordWidth = 32;
   localparam int RunWidth  = 6;
   localparam int SegWidth  = 8;

   localparam logic [WordWidth-1:0] AltMask = 32'hAAAA_AAAA;
   localparam logic [RunWidth-1:0]  FullRun = 6'd32;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [RunWidth-1:0]  run_type;
   typedef logic [SegWidth-1:0]  seg_type;

   typedef struct packed {
      run_type ones;
      run_type zeros;
      run_type alt;
   } runs_type;

   // step: the held word leaves the input register this cycle
   // last: that word is the list terminator
   typedef struct packed {
      logic step;
      logic last;
   } acc_ctrl_type;

   // Longest run of one bits. span[i] marks the start of every run of 2**i ones;
   // the run length is then built greedily from the largest power down.
   function automatic run_type longest_ones(input word_type v);
      word_type   span [5];
      word_type   cur;
      word_type   t;
      logic [4:0] n;
      span[0] = v;
      for (int i = 1; i < 5; i++) begin
         span[i] = span[i-1] & (span[i-1] >> (1 << (i - 1)));
      end
      cur = '1;
      n   = '0;
      for (int i = 4; i >= 0; i--) begin
         t = cur & (span[i] >> n);
         if (t != '0) begin
            cur = t;
            n   = n + 5'(1 << i);
         end
      end
      if (v == '1) begin
         return FullRun;
      end
      return {1'b0, n};
   endfunction

   function automatic seg_type seg_encode(input logic [3:0] d);
      seg_type s;
      case (d)
         4'd0:    s = 8'b0011_1111;
         4'd1:    s = 8'b0000_0110;
         4'd2:    s = 8'b0101_1011;
         4'd3:    s = 8'b0100_1111;
         4'd4:    s = 8'b0110_0110;
         4'd5:    s = 8'b0110_1101;
         4'd6:    s = 8'b0111_1101;
         4'd7:    s = 8'b0000_0111;
         4'd8:    s = 8'b0111_1111;
         4'd9:    s = 8'b0110_0111;
         default: s = 8'b0000_0000;
      endcase
      return s;
   endfunction

   // Tens byte above units byte; runs never exceed 32, so tens is 0..3.
   function automatic logic [2*SegWidth-1:0] digit_pair(input run_type v);
      logic [3:0] tens;
      logic [3:0] units;
      if (v >= 6'd30) begin
         tens  = 4'd3;
         units = 4'(v - 6'd30);
      end else if (v >= 6'd20) begin
         tens  = 4'd2;
         units = 4'(v - 6'd20);
      end else if (v >= 6'd10) begin
         tens  = 4'd1;
         units = 4'(v - 6'd10);
      end else begin
         tens  = 4'd0;
         units = v[3:0];
      end
      return {seg_encode(tens), seg_encode(units)};
   endfunction

endpackage

FILE: rtl/core/lbrt_if.sv
`timescale 1ns / 1ps

interface lbrt_req_if;
   logic              valid;
   logic              ready;
   lbrt_pkg::word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface lbrt_rsp_if;
   logic              valid;
   logic              ready;
   lbrt_pkg::run_type max_ones_run;
   lbrt_pkg::run_type max_zeros_run;
   lbrt_pkg::run_type max_alternating_run;
   logic [31:0]       segments_low;
   logic [15:0]       segments_high;

   modport source (output valid, output max_ones_run, output max_zeros_run,
                   output max_alternating_run, output segments_low,
                   output segments_high, input ready);
   modport sink   (input valid, input max_ones_run, input max_zeros_run,
                   input max_alternating_run, input segments_low,
                   input segments_high, output ready);
endinterface

FILE: rtl/core/lbrt_measure.sv
`timescale 1ns / 1ps

module lbrt_measure (
   input  lbrt_pkg::word_type word,
   output lbrt_pkg::runs_type runs
);

   lbrt_pkg::word_type alt_word;
   lbrt_pkg::run_type  alt_ones;
   lbrt_pkg::run_type  alt_zeros;

   assign alt_word  = word ^ lbrt_pkg::AltMask;
   assign alt_ones  = lbrt_pkg::longest_ones(alt_word);
   assign alt_zeros = lbrt_pkg::longest_ones(~alt_word);

   assign runs.ones  = lbrt_pkg::longest_ones(word);
   assign runs.zeros = lbrt_pkg::longest_ones(~word);
   assign runs.alt   = (alt_ones > alt_zeros) ? alt_ones : alt_zeros;

endmodule

FILE: rtl/core/lbrt_accum.sv
`timescale 1ns / 1ps

module lbrt_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  lbrt_pkg::acc_ctrl_type ctrl,
   input  lbrt_pkg::runs_type    runs,
   lbrt_rsp_if.source            rsp_bus
);

   lbrt_pkg::runs_type best_ff, best_in;
   logic               valid_ff, valid_in;
   lbrt_pkg::runs_type result_ff;
   logic [31:0]        seg_low_ff;
   logic [15:0]        seg_high_ff;

   always_comb begin
      best_in = best_ff;
      if (ctrl.step) begin
         if (ctrl.last) begin
            best_in = '0;
         end else begin
            best_in.ones  = (runs.ones > best_ff.ones) ? runs.ones : best_ff.ones;
            best_in.zeros = (runs.zeros > best_ff.zeros) ? runs.zeros : best_ff.zeros;
            best_in.alt   = (runs.alt > best_ff.alt) ? runs.alt : best_ff.alt;
         end
      end

      valid_in = valid_ff;
      if (ctrl.step && ctrl.last) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         best_ff  <= best_in;
         valid_ff <= valid_in;
      end
   end

   // Capture the maxima as they stand before the terminator clears them.
   always_ff @(posedge clock) begin
      if (ctrl.step && ctrl.last) begin
         result_ff   <= best_ff;
         seg_low_ff  <= {lbrt_pkg::digit_pair(best_ff.zeros),
                         lbrt_pkg::digit_pair(best_ff.ones)};
         seg_high_ff <= lbrt_pkg::digit_pair(best_ff.alt);
      end
   end

   assign rsp_bus.valid               = valid_ff;
   assign rsp_bus.max_ones_run        = result_ff.ones;
   assign rsp_bus.max_zeros_run       = result_ff.zeros;
   assign rsp_bus.max_alternating_run = result_ff.alt;
   assign rsp_bus.segments_low        = seg_low_ff;
   assign rsp_bus.segments_high       = seg_high_ff;

endmodule

FILE: rtl/core/longest_bit_run_tracker.sv
// A zero terminator is held in the input register until the output is free.
// Throughput: one word per cycle unless the terminator waits on a held result;
// the run measurement between the input register and the running-maximum
// registers is combinational. Data words never stall in the input register.
// Reset is synchronous, active high: clears the maxima and both valid flags.
`timescale 1ns / 1ps

module longest_bit_run_tracker (
   input  logic       clock,
   input  logic       reset,
   lbrt_req_if.sink   req_bus,
   lbrt_rsp_if.source rsp_bus
);

   logic                   s1_valid_ff, s1_valid_in;
   lbrt_pkg::word_type     s1_word_ff;
   logic                   is_last;
   logic                   out_free;
   logic                   advance;
   logic                   req_take;
   lbrt_pkg::runs_type     runs;
   lbrt_pkg::acc_ctrl_type ctrl;

   assign is_last  = (s1_word_ff == '0);
   assign out_free = !rsp_bus.valid || rsp_bus.ready;
   assign advance  = s1_valid_ff && (!is_last || out_free);

   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_bus.word;
      end
   end

   assign ctrl.step = advance;
   assign ctrl.last = is_last;

   lbrt_measure u_measure (
      .word (s1_word_ff),
      .runs (runs)
   );

   lbrt_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .runs    (runs),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTH
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && is_last && rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("terminator advanced over a held request");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> s1_valid_ff)
      else $error("accepted request not held in input register");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(s1_valid_ff && is_last))
      else $error("result raised without a terminator");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !is_last |-> req_bus.ready)
      else $error("data word stalled the input");
`endif

endmodule
